[rtl/variable_length_message_queue_assert.svh]
// Assertion macros shared by the message queue RTL.
`ifndef VARIABLE_LENGTH_MESSAGE_QUEUE_ASSERT_SVH
`define VARIABLE_LENGTH_MESSAGE_QUEUE_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define VLMQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset.
`define VLMQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/vlmq_pkg.sv]
// Types, codes and constants of the variable length message queue.
package vlmq_pkg;

    localparam int DEF_RING_ENTRIES = 128;
    localparam int DEF_STORE_BYTES  = 4096;
    localparam int MAX_MSG_BYTES    = 255;

    localparam int MODE_W    = 3;
    localparam int REQ_LEN_W = 16;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 12;
    localparam int LEN_W     = 8;
    localparam int STAT_W    = 3;
    localparam int CNT_W     = 7;
    localparam int DROP_W    = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_BEGIN  = 3'd0,
        MODE_BYTE   = 3'd1,
        MODE_PEEK   = 3'd2,
        MODE_READ   = 3'd3,
        MODE_COMMIT = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_RING_FULL  = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_UNEXPECTED = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_mode                mode;
        logic [REQ_LEN_W-1:0] msg_length;
        logic [BYTE_W-1:0]    data_byte;
        logic [IDX_W-1:0]     arena_index;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  msg_start;
        logic [LEN_W-1:0]  msg_len_out;
        logic [BYTE_W-1:0] read_data;
        logic [CNT_W-1:0]  queued_count;
        logic [DROP_W-1:0] drop_total;
    } t_result;

endpackage

[rtl/vlmq_ram.sv]
// Simple dual port synchronous RAM, one write and one registered read port.
module vlmq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/variable_length_message_queue.sv]
// Top level of the variable length message queue: descriptor ring plus byte arena.
// A command transferred in idle is registered with its RAM reads, worked on in the exec state,
// and its result is registered together with the result strobe. No new command is taken while
// busy in exec; the ring and arena RAMs return registered read data before the read-modify-write step.
// Reset: synchronous, active low; clears pointers, counters and the push in progress.
// The result strobe lasts one cycle and the receiver cannot hold it off.
module variable_length_message_queue
    import vlmq_pkg::*;
#(
    parameter int RING_ENTRIES = DEF_RING_ENTRIES,
    parameter int STORE_BYTES  = DEF_STORE_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    `include "variable_length_message_queue_assert.svh"

    localparam int RW     = $clog2(RING_ENTRIES);
    localparam int AW     = $clog2(STORE_BYTES);
    // arithmetic width for arena sums: covers store size and length, plus a carry
    localparam int SW     = ((AW > LEN_W) ? AW : LEN_W) + 2;
    localparam int DESC_W = AW + LEN_W;

    localparam logic [RW-1:0] RING_LAST  = RW'(RING_ENTRIES - 1);
    localparam logic [AW-1:0] STORE_LAST = AW'(STORE_BYTES - 1);
    localparam logic [SW-1:0] STORE_SZ   = SW'(STORE_BYTES);
    localparam logic [RW:0]   RING_SZ    = (RW + 1)'(RING_ENTRIES);

    // arena_index modulo store size: compare-subtract over shifted multiples
    function automatic logic [IDX_W-1:0] fold_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] v;
        v = idx;
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if ((longint'(STORE_BYTES) << k) < (longint'(1) << IDX_W)) begin
                if (v >= IDX_W'(STORE_BYTES << k)) begin
                    v = v - IDX_W'(STORE_BYTES << k);
                end
            end
        end
        return v;
    endfunction

    // control state
    t_state            r_state, n_state;
    logic              accept;

    // pointers and counters
    logic [RW-1:0]     r_wp, n_wp;
    logic [RW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_swp, n_swp;
    logic [AW-1:0]     r_sfp, n_sfp;
    logic [DROP_W-1:0] r_drop, n_drop;

    // push in progress
    logic [LEN_W-1:0]  r_brem, n_brem;
    logic [AW-1:0]     r_pstart, n_pstart;
    logic [LEN_W-1:0]  r_plen, n_plen;
    logic [AW-1:0]     r_wpos, n_wpos;

    // command under work and registered result
    t_cmd              r_cmd;
    logic              r_done;
    t_result           r_result, n_result;

    // RAM ports
    logic              ring_we;
    logic [DESC_W-1:0] ring_rdata;
    logic              arena_we;
    logic [BYTE_W-1:0] arena_rdata;
    logic [AW-1:0]     arena_raddr;

    // datapath helpers
    logic [LEN_W-1:0]  len_trim;
    logic [SW-1:0]     store_used;
    logic [SW-1:0]     store_avail;
    logic [SW-1:0]     msg_end;
    logic [SW-1:0]     pad_need;
    logic [SW-1:0]     commit_end;
    logic [RW-1:0]     wp_inc;
    logic [RW-1:0]     rp_inc;
    logic [AW-1:0]     wpos_inc;
    logic              ring_empty;
    logic [RW:0]       used_after;
    logic [AW-1:0]     rd_start;
    logic [LEN_W-1:0]  rd_len;
    t_status           status;

    assign rd_start    = ring_rdata[DESC_W-1:LEN_W];
    assign rd_len      = ring_rdata[LEN_W-1:0];
    assign arena_raddr = AW'(fold_index(i_cmd.arena_index));

    // descriptor ring: {start, length}, read at the ring read pointer
    vlmq_ram #(
        .DEPTH (RING_ENTRIES),
        .WIDTH (DESC_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_we),
        .i_wr_addr (r_wp),
        .i_wr_data ({r_pstart, r_plen}),
        .i_rd_en   (accept),
        .i_rd_addr (r_rp),
        .o_rd_data (ring_rdata)
    );

    // byte arena
    vlmq_ram #(
        .DEPTH (STORE_BYTES),
        .WIDTH (BYTE_W)
    ) u_arena (
        .i_clk     (i_clk),
        .i_wr_en   (arena_we),
        .i_wr_addr (r_wpos),
        .i_wr_data (r_cmd.data_byte),
        .i_rd_en   (accept),
        .i_rd_addr (arena_raddr),
        .o_rd_data (arena_rdata)
    );

    // sequencer: accept in idle, RAM data is ready in exec
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                busy    = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign accept = start && !busy;

    // shared arithmetic: begin push sizing, pointer increments and commit end
    always_comb begin
        if (r_cmd.msg_length > REQ_LEN_W'(MAX_MSG_BYTES)) begin
            len_trim = LEN_W'(MAX_MSG_BYTES);
        end else begin
            len_trim = r_cmd.msg_length[LEN_W-1:0];
        end
        if (r_swp >= r_sfp) begin
            store_used = SW'(r_swp) - SW'(r_sfp);
        end else begin
            store_used = SW'(r_swp) + STORE_SZ - SW'(r_sfp);
        end
        store_avail = STORE_SZ - store_used - SW'(1);
        msg_end     = SW'(r_swp) + SW'(len_trim);
        // padding to arena end plus the message placed at zero
        pad_need    = (STORE_SZ - SW'(r_swp)) + SW'(len_trim);
        commit_end  = SW'(rd_start) + SW'(rd_len);
        wp_inc      = (r_wp == RING_LAST) ? '0 : r_wp + RW'(1);
        rp_inc      = (r_rp == RING_LAST) ? '0 : r_rp + RW'(1);
        wpos_inc    = (r_wpos == STORE_LAST) ? '0 : r_wpos + AW'(1);
        ring_empty  = (r_wp == r_rp);
    end

    // read-modify-write step
    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_swp    = r_swp;
        n_sfp    = r_sfp;
        n_drop   = r_drop;
        n_brem   = r_brem;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_wpos   = r_wpos;
        ring_we  = 1'b0;
        arena_we = 1'b0;
        status   = ST_OK;
        n_result = r_result;

        if (r_state == S_EXEC) begin
            n_result.msg_start   = '0;
            n_result.msg_len_out = '0;
            n_result.read_data   = '0;
            unique case (r_cmd.mode)
                MODE_BEGIN: begin
                    // any unfinished push is abandoned
                    n_brem = '0;
                    if (len_trim == '0) begin
                        status = ST_OK;
                    end else if (wp_inc == r_rp) begin
                        status = ST_RING_FULL;
                        n_drop = r_drop + DROP_W'(1);
                    end else if (SW'(len_trim) > store_avail) begin
                        status = ST_NO_SPACE;
                        n_drop = r_drop + DROP_W'(1);
                    end else if (msg_end > STORE_SZ && pad_need > store_avail) begin
                        status = ST_NO_SPACE;
                        n_drop = r_drop + DROP_W'(1);
                    end else begin
                        n_pstart = (msg_end > STORE_SZ) ? '0 : r_swp;
                        n_wpos   = (msg_end > STORE_SZ) ? '0 : r_swp;
                        n_plen   = len_trim;
                        n_brem   = len_trim;
                    end
                end
                MODE_BYTE: begin
                    if (r_brem == '0) begin
                        status = ST_UNEXPECTED;
                    end else begin
                        arena_we = 1'b1;
                        n_wpos   = wpos_inc;
                        n_brem   = r_brem - LEN_W'(1);
                        if (r_brem == LEN_W'(1)) begin
                            // last byte: publish the descriptor
                            ring_we = 1'b1;
                            n_wp    = wp_inc;
                            n_swp   = wpos_inc;
                        end
                    end
                end
                MODE_PEEK: begin
                    if (ring_empty) begin
                        status = ST_EMPTY;
                    end else begin
                        n_result.msg_start   = IDX_W'(rd_start);
                        n_result.msg_len_out = rd_len;
                    end
                end
                MODE_READ: begin
                    n_result.read_data = arena_rdata;
                end
                MODE_COMMIT: begin
                    if (ring_empty) begin
                        status = ST_EMPTY;
                    end else begin
                        // frees the message and any wrap padding ahead of it
                        n_sfp = (commit_end == STORE_SZ) ? '0 : AW'(commit_end);
                        n_rp  = rp_inc;
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase

            if (n_wp >= n_rp) begin
                used_after = (RW + 1)'(n_wp) - (RW + 1)'(n_rp);
            end else begin
                used_after = (RW + 1)'(n_wp) + RING_SZ - (RW + 1)'(n_rp);
            end
            n_result.status       = status;
            n_result.queued_count = CNT_W'(used_after);
            n_result.drop_total   = n_drop;
        end else begin
            used_after = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_swp    <= '0;
            r_sfp    <= '0;
            r_drop   <= '0;
            r_brem   <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_wpos   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_swp    <= n_swp;
            r_sfp    <= n_sfp;
            r_drop   <= n_drop;
            r_brem   <= n_brem;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_wpos   <= n_wpos;
            r_done   <= (r_state == S_EXEC);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `VLMQ_ASSERT(a_done_follows_exec, i_clk, i_rst_n, r_done |-> $past(r_state == S_EXEC), "result strobe without an exec cycle")
    `VLMQ_ASSERT(a_accept_goes_busy, i_clk, i_rst_n, accept |=> busy, "transfer did not start exec")
    `VLMQ_ASSERT(a_pending_fits, i_clk, i_rst_n, (r_brem != '0) |-> ((SW'(r_pstart) + SW'(r_plen)) <= STORE_SZ), "pending message runs past arena end")
    `VLMQ_ASSERT(a_remaining_bounded, i_clk, i_rst_n, r_brem <= r_plen, "more bytes remaining than reserved")
    `VLMQ_ASSERT_ALWAYS(a_single_strobe, i_clk, r_done |=> !r_done, "result strobe held longer than one cycle")

endmodule

[tb/tb_variable_length_message_queue.sv]
// Self-checking testbench for the variable length message queue (descriptor ring + byte arena).
module tb_variable_length_message_queue;
    import vlmq_pkg::*;

    // Shadow sizes; the block runs at its default parameters.
    localparam int RING           = DEF_RING_ENTRIES;
    localparam int ARENA          = DEF_STORE_BYTES;
    localparam int BACKLOG_MAX    = 64;     // generator runs at most this far ahead
    localparam int ITEM_TARGET    = 1400;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any command transfer
    localparam int PRINT_LIMIT    = 30;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    cmd     = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    variable_length_message_queue uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the queue state, advanced once per command transfer.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  slot_start [RING];
    logic [LEN_W-1:0]  slot_len   [RING];
    logic [BYTE_W-1:0] arena      [ARENA];   // left X; never read before written
    bit                arena_written [ARENA];
    logic [CNT_W-1:0]  ring_wr    = '0;
    logic [CNT_W-1:0]  ring_rd    = '0;
    logic [IDX_W-1:0]  arena_wr   = '0;      // advances only on publish
    logic [IDX_W-1:0]  arena_free = '0;      // oldest byte still held
    logic [DROP_W-1:0] drops      = '0;
    logic [LEN_W-1:0]  fill_left  = '0;      // bytes owed by the open push; 0 = none open
    logic [IDX_W-1:0]  open_start = '0;
    logic [LEN_W-1:0]  open_len   = '0;

    // Bookkeeping for the end-of-run summary and the stop condition.
    int unsigned status_tally [5];
    int unsigned published  = 0;
    int unsigned wrap_pads  = 0;
    int unsigned arena_reads = 0;
    int unsigned transfers  = 0;
    int unsigned stim_items = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    t_cmd    cmd_backlog [$];   // commands waiting for the driver
    t_result answers_due [$];   // predicted results, oldest first

    // Works out the answer to one command and applies its side effects.
    function automatic t_result queue_answer(t_cmd c);
        t_result     r;
        int unsigned want_len;
        int unsigned avail;
        int unsigned place;
        int unsigned pos;
        bit          padded;
        r        = '0;
        r.status = ST_OK;
        padded   = 1'b0;
        case (c.mode)
            MODE_BEGIN: begin
                // Any open push is abandoned, whatever this begin turns into.
                fill_left = '0;
                want_len  = (c.msg_length > MAX_MSG_BYTES) ? MAX_MSG_BYTES : c.msg_length;
                if (want_len != 0) begin
                    // One arena byte is always kept free.
                    avail = ARENA - ((arena_wr + ARENA - arena_free) % ARENA) - 1;
                    place = 32'(arena_wr);
                    // 7-bit compare: wraps with the ring.
                    if ((ring_wr + 1'b1) == ring_rd) begin
                        r.status = ST_RING_FULL;
                    end else if (want_len > avail) begin
                        r.status = ST_NO_SPACE;
                    end else if (place + want_len > ARENA) begin
                        // Won't fit before the arena end: skip to 0, tail is padding.
                        if ((ARENA - place) + want_len > avail) begin
                            r.status = ST_NO_SPACE;
                        end else begin
                            place  = 0;
                            padded = 1'b1;
                        end
                    end
                    if (r.status != ST_OK) begin
                        drops = drops + 1'b1;
                    end else begin
                        open_start = IDX_W'(place);
                        open_len   = LEN_W'(want_len);
                        fill_left  = LEN_W'(want_len);
                        if (padded) wrap_pads++;
                    end
                end
            end
            MODE_BYTE: begin
                if (fill_left == 0) begin
                    r.status = ST_UNEXPECTED;
                end else begin
                    pos = (open_start + open_len - fill_left) % ARENA;
                    arena[pos]         = c.data_byte;
                    arena_written[pos] = 1'b1;
                    fill_left          = fill_left - 1'b1;
                    if (fill_left == 0) begin
                        // Last byte publishes the descriptor.
                        arena_wr          = IDX_W'((open_start + open_len) % ARENA);
                        slot_start[ring_wr] = open_start;
                        slot_len[ring_wr]   = open_len;
                        ring_wr           = ring_wr + 1'b1;
                        published++;
                    end
                end
            end
            MODE_PEEK: begin
                if (ring_wr == ring_rd) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.msg_start   = slot_start[ring_rd];
                    r.msg_len_out = slot_len[ring_rd];
                end
            end
            MODE_READ: begin
                r.read_data = arena[c.arena_index];
                arena_reads++;
            end
            MODE_COMMIT: begin
                if (ring_wr == ring_rd) begin
                    r.status = ST_EMPTY;
                end else begin
                    // Free pointer jumps to the message end, releasing padding too.
                    arena_free = slot_start[ring_rd] + slot_len[ring_rd];
                    ring_rd    = ring_rd + 1'b1;
                end
            end
            default: ;
        endcase
        r.queued_count = ring_wr - ring_rd;
        r.drop_total   = drops;
        status_tally[r.status]++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one command per transfer, random idle gaps between them.
    // ------------------------------------------------------------------
    int calm_left = 0;   // commands left in a stretch with no gaps
    int idle_left = 0;

    function automatic int draw_gap();
        int unsigned pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin : command_driver
        int   idle_now;
        t_cmd next_cmd;
        if (!i_rst_n) begin
            start     <= 1'b0;
            cmd       <= '0;
            idle_left <= 0;
        end else if (!start || !busy) begin
            if (start) begin
                // Transfer at this edge: predict now, in transfer order.
                answers_due.push_back(queue_answer(cmd));
                transfers++;
                idle_now = draw_gap();
            end else begin
                idle_now = idle_left;
            end
            if (idle_now == 0 && cmd_backlog.size() != 0) begin
                next_cmd  = cmd_backlog.pop_front();
                cmd       <= next_cmd;
                start     <= 1'b1;
                idle_left <= 0;
            end else begin
                start     <= 1'b0;
                idle_left <= (idle_now > 0) ? idle_now - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed result is checked against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, what);
        else if (mismatches == PRINT_LIMIT + 1)
            $display("[%0t] further mismatches counted but not printed", $time);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                report_mismatch("result strobe with no command outstanding");
            end else begin
                want = answers_due.pop_front();
                compare_field("status",       o_result.status,       want.status);
                compare_field("msg_start",    o_result.msg_start,    want.msg_start);
                compare_field("msg_len_out",  o_result.msg_len_out,  want.msg_len_out);
                compare_field("read_data",    o_result.read_data,    want.read_data);
                compare_field("queued_count", o_result.queued_count, want.queued_count);
                compare_field("drop_total",   o_result.drop_total,   want.drop_total);
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles, %0d pending",
                         $time, WATCHDOG_LIMIT, answers_due.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Shadow state is only read at the falling edge.
    // ------------------------------------------------------------------
    function automatic logic [REQ_LEN_W-1:0] rnd_len();
        return REQ_LEN_W'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] rnd_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] rnd_idx();
        return IDX_W'($urandom);
    endfunction

    task automatic queue_cmd(t_mode m, logic [REQ_LEN_W-1:0] len,
                             logic [BYTE_W-1:0] data, logic [IDX_W-1:0] idx);
        t_cmd c;
        while (cmd_backlog.size() >= BACKLOG_MAX) @(negedge i_clk);
        c.mode        = m;
        c.msg_length  = len;
        c.data_byte   = data;
        c.arena_index = idx;
        cmd_backlog.push_back(c);
        stim_items++;
    endtask

    // Returns once every queued command has transferred and been predicted.
    task automatic wait_drained();
        do @(negedge i_clk); while (cmd_backlog.size() != 0 || start);
    endtask

    // Nearest written arena position at or after 'from', or -1 if none yet.
    function automatic int written_near(int from);
        for (int k = 0; k < ARENA; k++)
            if (arena_written[(from + k) % ARENA]) return (from + k) % ARENA;
        return -1;
    endfunction

    task automatic read_back(int count);
        int found;
        wait_drained();
        repeat (count) begin
            found = written_near($urandom_range(0, ARENA - 1));
            if (found >= 0) queue_cmd(MODE_READ, rnd_len(), rnd_byte(), IDX_W'(found));
        end
    endtask

    // Begin plus 'nbytes' data bytes; optionally a peek or commit mid-push.
    task automatic send_message(logic [REQ_LEN_W-1:0] len, int nbytes, bit interleave);
        int cut;
        queue_cmd(MODE_BEGIN, len, rnd_byte(), rnd_idx());
        cut = interleave ? $urandom_range(0, nbytes) : -1;
        for (int k = 0; k < nbytes; k++) begin
            if (k == cut)
                queue_cmd(($urandom_range(0, 1) != 0) ? MODE_PEEK : MODE_COMMIT,
                          rnd_len(), rnd_byte(), rnd_idx());
            queue_cmd(MODE_BYTE, rnd_len(), rnd_byte(), rnd_idx());
        end
    endtask

    // Mostly short messages, some long, a few over the limit (cut to max).
    function automatic logic [REQ_LEN_W-1:0] draw_msg_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)  return 0;
        if (pick < 50) return REQ_LEN_W'($urandom_range(1, 16));
        if (pick < 82) return REQ_LEN_W'($urandom_range(17, 120));
        if (pick < 94) return REQ_LEN_W'($urandom_range(200, MAX_MSG_BYTES));
        return REQ_LEN_W'($urandom_range(MAX_MSG_BYTES + 1, 65535));
    endfunction

    function automatic int clipped(logic [REQ_LEN_W-1:0] len);
        return (len > MAX_MSG_BYTES) ? MAX_MSG_BYTES : len;
    endfunction

    initial begin : stimulus
        logic [REQ_LEN_W-1:0] len;
        logic [IDX_W-1:0]     held;
        int                   eff;
        int                   pick;
        int                   backlog_msgs;

        for (int k = 0; k < RING; k++) begin
            slot_start[k] = '0;
            slot_len[k]   = '0;
        end
        for (int k = 0; k < ARENA; k++) arena_written[k] = 1'b0;
        for (int k = 0; k < 5; k++) status_tally[k] = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed: corner cases right out of reset ----
        queue_cmd(MODE_BYTE,   16'h0000, 8'hFF, 12'hFFF);  // stray byte, nothing open
        queue_cmd(MODE_PEEK,   16'h0000, 8'h00, 12'h000);  // empty ring
        queue_cmd(MODE_COMMIT, 16'h0000, 8'h00, 12'h000);  // empty ring
        queue_cmd(MODE_BEGIN,  16'h0000, 8'h00, 12'h000);  // zero length: ok, nothing kept
        queue_cmd(MODE_BYTE,   16'h0000, 8'h00, 12'h000);  // still stray after it
        queue_cmd(MODE_BEGIN,  16'hFFFF, 8'h00, 12'hFFF);  // cut down to max length
        queue_cmd(MODE_BYTE,   16'hFFFF, 8'h12, 12'h000);
        queue_cmd(MODE_BYTE,   16'hFFFF, 8'h34, 12'h000);
        queue_cmd(MODE_BEGIN,  16'd3,    8'h00, 12'h000);  // abandons the long push
        queue_cmd(MODE_PEEK,   16'h0000, 8'h00, 12'h000);  // open push is not visible
        queue_cmd(MODE_BYTE,   16'h0000, 8'h00, 12'h000);
        queue_cmd(MODE_BYTE,   16'h0000, 8'hFF, 12'h000);
        queue_cmd(MODE_BYTE,   16'h0000, 8'h5A, 12'h000);  // publishes at arena 0
        queue_cmd(MODE_PEEK,   16'h0000, 8'h00, 12'h000);
        queue_cmd(MODE_READ,   16'h0000, 8'h00, 12'h000);
        queue_cmd(MODE_READ,   16'h0000, 8'h00, 12'h001);
        queue_cmd(MODE_READ,   16'h0000, 8'h00, 12'h002);
        queue_cmd(MODE_COMMIT, 16'h0000, 8'h00, 12'h000);
        queue_cmd(MODE_COMMIT, 16'h0000, 8'h00, 12'h000);  // empty again
        queue_cmd(MODE_BEGIN,  16'd256,  8'h00, 12'h000);  // just over max
        queue_cmd(MODE_BEGIN,  16'd1,    8'h00, 12'h000);  // abandons it
        queue_cmd(MODE_BYTE,   16'h0000, 8'h80, 12'h000);
        queue_cmd(MODE_PEEK,   16'h0000, 8'h00, 12'h000);
        queue_cmd(MODE_COMMIT, 16'h0000, 8'h00, 12'h000);

        // ---- Fill the ring with one-byte messages until it refuses ----
        wait_drained();
        backlog_msgs = int'(CNT_W'(ring_wr - ring_rd));
        repeat (backlog_msgs) queue_cmd(MODE_COMMIT, rnd_len(), rnd_byte(), rnd_idx());
        repeat (RING - 1) send_message(16'd1, 1, 1'b0);
        queue_cmd(MODE_BEGIN, 16'd1,     rnd_byte(), rnd_idx());  // ring full
        queue_cmd(MODE_BEGIN, 16'hFFFF,  rnd_byte(), rnd_idx());  // ring full, long
        queue_cmd(MODE_BYTE,  rnd_len(), rnd_byte(), rnd_idx());  // nothing open now
        queue_cmd(MODE_PEEK,  rnd_len(), rnd_byte(), rnd_idx());
        repeat (RING) queue_cmd(MODE_COMMIT, rnd_len(), rnd_byte(), rnd_idx());

        // ---- Random part: mostly complete messages, some noise ----
        // Runs until the item budget is used up.
        while (stim_items < ITEM_TARGET) begin
            held = arena_wr - arena_free;   // bytes held, slightly stale is fine
            pick = $urandom_range(0, 99);
            if (held > 3600 && $urandom_range(0, 99) < 60) pick = 80;
            if (pick < 44) begin
                len = draw_msg_length();
                send_message(len, clipped(len), $urandom_range(0, 9) == 0);
            end else if (pick < 50) begin
                // Broken sequence: stops short, the next begin abandons it.
                len = draw_msg_length();
                eff = clipped(len);
                send_message(len, (eff == 0) ? 0 : $urandom_range(0, eff - 1), 1'b0);
            end else if (pick < 60) begin
                queue_cmd(MODE_PEEK, rnd_len(), rnd_byte(), rnd_idx());
            end else if (pick < 70) begin
                read_back($urandom_range(1, 4));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3))
                    queue_cmd(MODE_COMMIT, rnd_len(), rnd_byte(), rnd_idx());
            end else if (pick < 95) begin
                queue_cmd(MODE_BYTE, rnd_len(), rnd_byte(), rnd_idx());
            end else begin
                queue_cmd(MODE_BEGIN, 16'h0000, rnd_byte(), rnd_idx());
            end
        end

        // ---- Drain, then a short tail to catch stray strobes ----
        wait_drained();
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d transfers: %0d messages published, %0d wrap placements, %0d reads",
                 transfers, published, wrap_pads, arena_reads);
        $display("Statuses: ok %0d, ring full %0d, no space %0d, empty %0d, stray byte %0d",
                 status_tally[ST_OK], status_tally[ST_RING_FULL], status_tally[ST_NO_SPACE],
                 status_tally[ST_EMPTY], status_tally[ST_UNEXPECTED]);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
